[hw/rtl/btm_pkg.sv]
// ----------------------------------------------------------------------------
// btm_pkg
// Shared types and constants of the binary template matcher.
// ----------------------------------------------------------------------------
package btm_pkg;

   localparam int SIDE_W = 7;
   localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;
   localparam int N_ORIENT = 8;

   localparam logic OP_TEMPLATE = 1'b0;
   localparam logic OP_CARD     = 1'b1;

   // position control
   typedef struct packed {
      logic clear;
      logic tpl_step;
      logic card_step;
   } step_type;

   // compare stage status
   typedef struct packed {
      logic valid;
      logic last;
   } stage_type;

endpackage

[hw/rtl/btm_ifs.sv]
// ----------------------------------------------------------------------------
// btm channel interfaces
// Pixel request, match response and side length write channels.
// ----------------------------------------------------------------------------
interface btm_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic pixel;

   modport source (output valid, output operation, output pixel, input ready);
   modport sink (input valid, input operation, input pixel, output ready);
endinterface

interface btm_rsp_if;
   logic valid;
   logic ready;
   logic match;

   modport source (output valid, output match, input ready);
   modport sink (input valid, input match, output ready);
endinterface

interface btm_csr_if;
   logic                        valid;
   logic                        ready;
   logic [btm_pkg::SIDE_W-1:0]  side_length;

   modport source (output valid, output side_length, input ready);
   modport sink (input valid, input side_length, output ready);
endinterface

[hw/rtl/btm_pos.sv]
// ----------------------------------------------------------------------------
// btm_pos
// Raster position counters for template writes and card reads.
// ----------------------------------------------------------------------------
module btm_pos #(
   parameter int MAX_SIDE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  btm_pkg::step_type             step,
   input  logic [$clog2(MAX_SIDE)-1:0]   last_idx,
   output logic [$clog2(MAX_SIDE)-1:0]   tpl_row,
   output logic [$clog2(MAX_SIDE)-1:0]   tpl_col,
   output logic [$clog2(MAX_SIDE)-1:0]   card_row,
   output logic [$clog2(MAX_SIDE)-1:0]   card_col,
   output logic                          card_last
);
   import btm_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);

   logic [CW-1:0] tpl_row_ff, tpl_col_ff, card_row_ff, card_col_ff;
   logic [CW-1:0] tpl_row_in, tpl_col_in, card_row_in, card_col_in;

   always_comb begin
      tpl_row_in  = tpl_row_ff;
      tpl_col_in  = tpl_col_ff;
      card_row_in = card_row_ff;
      card_col_in = card_col_ff;
      if (step.tpl_step) begin
         if (tpl_col_ff == last_idx) begin
            tpl_col_in = '0;
            // wrap to the start after the last template pixel
            tpl_row_in = (tpl_row_ff == last_idx) ? '0 : tpl_row_ff + 1'b1;
         end else begin
            tpl_col_in = tpl_col_ff + 1'b1;
         end
      end
      if (step.card_step) begin
         if (card_col_ff == last_idx) begin
            card_col_in = '0;
            card_row_in = (card_row_ff == last_idx) ? '0 : card_row_ff + 1'b1;
         end else begin
            card_col_in = card_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || step.clear) begin
         tpl_row_ff  <= '0;
         tpl_col_ff  <= '0;
         card_row_ff <= '0;
         card_col_ff <= '0;
      end else begin
         tpl_row_ff  <= tpl_row_in;
         tpl_col_ff  <= tpl_col_in;
         card_row_ff <= card_row_in;
         card_col_ff <= card_col_in;
      end
   end

   assign tpl_row   = tpl_row_ff;
   assign tpl_col   = tpl_col_ff;
   assign card_row  = card_row_ff;
   assign card_col  = card_col_ff;
   assign card_last = (card_row_ff == last_idx) && (card_col_ff == last_idx);

endmodule

[hw/rtl/btm_tmem.sv]
// ----------------------------------------------------------------------------
// btm_tmem
// Template store: eight copies written together, each read at the position
// of one rotation or reflection, read data registered.
// ----------------------------------------------------------------------------
module btm_tmem #(
   parameter int MAX_SIDE = 64
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_SIDE)-1:0]         wr_row,
   input  logic [$clog2(MAX_SIDE)-1:0]         wr_col,
   input  logic                                wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(MAX_SIDE)-1:0]         rd_row,
   input  logic [$clog2(MAX_SIDE)-1:0]         rd_col,
   input  logic [$clog2(MAX_SIDE)-1:0]         last_idx,
   output logic [btm_pkg::N_ORIENT-1:0]        rd_data
);
   import btm_pkg::*;

   localparam int CW    = $clog2(MAX_SIDE);
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] SideA = AW'(MAX_SIDE);

   logic [CW-1:0] inv_row, inv_col;
   logic [CW-1:0] map_row [N_ORIENT];
   logic [CW-1:0] map_col [N_ORIENT];
   logic [AW-1:0] rd_addr [N_ORIENT];
   logic [AW-1:0] wr_addr;
   logic [N_ORIENT-1:0] rd_data_ff;

   assign inv_row = last_idx - rd_row;
   assign inv_col = last_idx - rd_col;

   // the eight dihedral maps of (row, col)
   always_comb begin
      map_row[0] = rd_row;  map_col[0] = rd_col;
      map_row[1] = rd_col;  map_col[1] = inv_row;
      map_row[2] = inv_row; map_col[2] = inv_col;
      map_row[3] = inv_col; map_col[3] = rd_row;
      map_row[4] = inv_row; map_col[4] = rd_col;
      map_row[5] = rd_row;  map_col[5] = inv_col;
      map_row[6] = rd_col;  map_col[6] = rd_row;
      map_row[7] = inv_col; map_col[7] = inv_row;
   end

   assign wr_addr = AW'(AW'(wr_row) * SideA) + AW'(wr_col);

   for (genvar k = 0; k < N_ORIENT; k++) begin : g_copy
      logic mem [DEPTH];

      assign rd_addr[k] = AW'(AW'(map_row[k]) * SideA) + AW'(map_col[k]);

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_data_ff[k] <= mem[rd_addr[k]];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/btm_flags.sv]
// ----------------------------------------------------------------------------
// btm_flags
// Compare stage: checks the card pixel against the eight template reads and
// accumulates the mismatch flags of the card.
// ----------------------------------------------------------------------------
module btm_flags (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          hold,
   input  logic                          card_in,
   input  logic                          last_in,
   input  logic                          pixel_in,
   input  logic [btm_pkg::N_ORIENT-1:0]  rd_data,
   output btm_pkg::stage_type            stage,
   output logic                          match
);
   import btm_pkg::*;

   logic                valid_ff, last_ff, pixel_ff;
   logic [N_ORIENT-1:0] flags_ff;
   logic [N_ORIENT-1:0] flags_in;

   assign flags_in = flags_ff | (rd_data ^ {N_ORIENT{pixel_ff}});

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
         flags_ff <= '0;
      end else if (!hold) begin
         valid_ff <= card_in;
         if (valid_ff) begin
            flags_ff <= last_ff ? '0 : flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         last_ff  <= last_in;
         pixel_ff <= pixel_in;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.last  = last_ff;
   assign match       = (flags_in != {N_ORIENT{1'b1}});

endmodule

[hw/rtl/binary_template_match_rotate_flip.sv]
// ----------------------------------------------------------------------------
// binary_template_match_rotate_flip
// Result path: the compare stage register, then the response register.
// Throughput: one pixel per cycle, template or card; the only stall is when
// a finished result is still waiting and the next one is ready to leave.
// The eight template copies give eight reads in one cycle.
// Reset clears positions and flags and sets side length to 64; template is unset.
// ----------------------------------------------------------------------------
module binary_template_match_rotate_flip #(
   parameter int MAX_SIDE = 64
) (
   input  logic         clock,
   input  logic         reset,
   btm_req_if.sink      req_if,
   btm_rsp_if.source    rsp_if,
   btm_csr_if.sink      csr_if
);
   import btm_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);

   logic [SIDE_W-1:0] side_ff;
   logic [31:0]       side_ext, n_eff;
   logic [CW-1:0]     last_idx;
   logic              cfg_wr, req_xfer, tpl_wr, card_rd, blocked, done;
   logic              rsp_valid_ff, match_ff, match_w;
   logic [CW-1:0]     tpl_row, tpl_col, card_row, card_col;
   logic              card_last;
   logic [N_ORIENT-1:0] rd_data;
   step_type          step;
   stage_type         stage;

   assign csr_if.ready = 1'b1;
   assign cfg_wr       = csr_if.valid;

   // side zero acts as one, oversize clamps to the store
   assign side_ext = 32'(side_ff);
   assign n_eff    = (side_ext == 32'd0) ? 32'd1
                   : ((side_ext > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : side_ext);
   assign last_idx = CW'(n_eff - 32'd1);

   assign req_if.ready = !(stage.valid && stage.last && rsp_valid_ff);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign tpl_wr       = req_xfer && (req_if.operation == OP_TEMPLATE);
   assign card_rd      = req_xfer && (req_if.operation == OP_CARD);

   assign blocked = stage.valid && stage.last && rsp_valid_ff && !rsp_if.ready;
   assign done    = stage.valid && stage.last && !blocked;

   assign step.clear     = cfg_wr;
   assign step.tpl_step  = tpl_wr;
   assign step.card_step = card_rd;

   btm_pos #(.MAX_SIDE(MAX_SIDE)) u_pos (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .last_idx  (last_idx),
      .tpl_row   (tpl_row),
      .tpl_col   (tpl_col),
      .card_row  (card_row),
      .card_col  (card_col),
      .card_last (card_last)
   );

   btm_tmem #(.MAX_SIDE(MAX_SIDE)) u_tmem (
      .clock    (clock),
      .wr_en    (tpl_wr),
      .wr_row   (tpl_row),
      .wr_col   (tpl_col),
      .wr_data  (req_if.pixel),
      .rd_en    (card_rd),
      .rd_row   (card_row),
      .rd_col   (card_col),
      .last_idx (last_idx),
      .rd_data  (rd_data)
   );

   btm_flags u_flags (
      .clock    (clock),
      .reset    (reset),
      .clear    (cfg_wr),
      .hold     (blocked),
      .card_in  (card_rd),
      .last_in  (card_last),
      .pixel_in (req_if.pixel),
      .rd_data  (rd_data),
      .stage    (stage),
      .match    (match_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= SIDE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            side_ff <= csr_if.side_length;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         match_ff <= match_w;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.match = match_ff;

endmodule
